@@ hdl/atss_pkg.sv @@
package atss_pkg;

   localparam int SAMPLE_W = 10;
   localparam int SCALED_W = 12;
   localparam int AVG_W = 12;
   localparam int DIGIT_W = 4;
   localparam int SEG_W = 7;

   localparam int SCALED_MAX = 4000;
   localparam int SCALE_NUM = 400;
   localparam int ADC_FULL = 1023;
   localparam int DIGIT_BASE = 10;

   // Reciprocal of the converter full scale: floor(p * 1025 / 2^20) is
   // never above floor(p / 1023) and at most one below it.
   localparam int SCALE_PROD_W = 19;
   localparam int SCALE_QUOT_W = 9;
   localparam int SCALE_EST_W = 30;
   localparam int RECIP_FULL = 1025;
   localparam int RECIP_FULL_SHIFT = 20;

   // Exact division by ten for the ranges used in the digit split.
   localparam int RECIP_TEN_WIDE = 52429;
   localparam int RECIP_TEN_WIDE_SHIFT = 19;
   localparam int RECIP_TEN_WIDE_W = 28;
   localparam int RECIP_TEN_NARROW = 205;
   localparam int RECIP_TEN_NARROW_SHIFT = 11;
   localparam int RECIP_TEN_NARROW_W = 20;
   localparam int TENS_W = 9;
   localparam int HUNDREDS_W = 6;

   localparam logic [SEG_W-1:0] SEG_BLANK = 7'h7F;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [SEG_W-1:0] segments_type;

   function automatic segments_type seg_pattern(input digit_type digit);
      segments_type pattern;
      case (digit)
         4'd0: pattern = 7'h40;
         4'd1: pattern = 7'h79;
         4'd2: pattern = 7'h24;
         4'd3: pattern = 7'h30;
         4'd4: pattern = 7'h19;
         4'd5: pattern = 7'h12;
         4'd6: pattern = 7'h02;
         4'd7: pattern = 7'h78;
         4'd8: pattern = 7'h00;
         4'd9: pattern = 7'h10;
         default: pattern = SEG_BLANK;
      endcase
      return pattern;
   endfunction

endpackage

@@ hdl/atss_scale.sv @@
module atss_scale
   import atss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [SAMPLE_W-1:0] sample,
   output logic                out_valid,
   output logic [SCALED_W-1:0] value
);

   logic [SCALE_PROD_W-1:0] prod_in, prod_ff;
   logic [SCALE_EST_W-1:0]  est_wide;
   logic [SCALE_QUOT_W-1:0] quot_in, quot_ff;
   logic                    stage1_valid_ff;
   logic [SCALE_PROD_W-1:0] rem;
   logic [SCALE_QUOT_W-1:0] quot_fixed;
   logic [SCALED_W-1:0]     value_in, value_ff;
   logic                    stage2_valid_ff;

   always_comb begin
      prod_in  = SCALE_PROD_W'(sample) * SCALE_PROD_W'(SCALE_NUM);
      est_wide = SCALE_EST_W'(prod_in) * SCALE_EST_W'(RECIP_FULL);
      quot_in  = est_wide[RECIP_FULL_SHIFT +: SCALE_QUOT_W];
   end

   always_comb begin
      rem        = prod_ff - SCALE_PROD_W'(quot_ff) * SCALE_PROD_W'(ADC_FULL);
      quot_fixed = quot_ff + SCALE_QUOT_W'(rem >= SCALE_PROD_W'(ADC_FULL));
      value_in   = SCALED_W'(quot_fixed) * SCALED_W'(DIGIT_BASE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_valid_ff <= 1'b0;
         stage2_valid_ff <= 1'b0;
      end else if (en) begin
         stage1_valid_ff <= in_valid;
         stage2_valid_ff <= stage1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         quot_ff  <= quot_in;
         value_ff <= value_in;
      end
   end

   assign out_valid = stage2_valid_ff;
   assign value     = value_ff;

endmodule

@@ hdl/atss_cell.sv @@
module atss_cell
   import atss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic [SCALED_W-1:0] d_in,
   output logic [SCALED_W-1:0] d_out
);

   logic [SCALED_W-1:0] sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= d_in;
      end
   end

   assign d_out = sample_ff;

endmodule

@@ hdl/atss_digits.sv @@
module atss_digits
   import atss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [AVG_W-1:0] average,
   output logic             out_valid,
   output logic [AVG_W-1:0] out_average,
   output digit_type        tens_digit,
   output digit_type        units_digit,
   output digit_type        tenths_digit,
   output segments_type     tens_segments,
   output segments_type     units_segments,
   output segments_type     tenths_segments
);

   logic [RECIP_TEN_WIDE_W-1:0]   tens_prod;
   logic [TENS_W-1:0]             tens_in, tens6_ff, tens7_ff;
   logic [AVG_W-1:0]              avg6_ff, avg7_ff;
   logic                          valid6_ff, valid7_ff, valid8_ff;
   logic [RECIP_TEN_NARROW_W-1:0] hund_prod;
   logic [HUNDREDS_W-1:0]         hund_in, hund_ff;
   logic [AVG_W-1:0]              tenths_wide;
   digit_type                     tenths_in, tenths7_ff;
   logic [TENS_W-1:0]             units_wide;
   logic [RECIP_TEN_NARROW_W-1:0] thou_prod;
   logic [HUNDREDS_W-1:0]         thou;
   logic [HUNDREDS_W-1:0]         tens_wide;
   digit_type                     units_in, tens_digit_in;
   logic [AVG_W-1:0]              avg8_ff;
   digit_type                     tens8_ff, units8_ff, tenths8_ff;
   segments_type                  tens_seg_ff, units_seg_ff, tenths_seg_ff;

   always_comb begin
      tens_prod = RECIP_TEN_WIDE_W'(average) * RECIP_TEN_WIDE_W'(RECIP_TEN_WIDE);
      tens_in   = tens_prod[RECIP_TEN_WIDE_SHIFT +: TENS_W];
   end

   always_comb begin
      tenths_wide = avg6_ff - AVG_W'(tens6_ff) * AVG_W'(DIGIT_BASE);
      tenths_in   = tenths_wide[DIGIT_W-1:0];
      hund_prod   = RECIP_TEN_NARROW_W'(tens6_ff)
                    * RECIP_TEN_NARROW_W'(RECIP_TEN_NARROW);
      hund_in     = hund_prod[RECIP_TEN_NARROW_SHIFT +: HUNDREDS_W];
   end

   always_comb begin
      units_wide    = tens7_ff - TENS_W'(hund_ff) * TENS_W'(DIGIT_BASE);
      units_in      = units_wide[DIGIT_W-1:0];
      thou_prod     = RECIP_TEN_NARROW_W'(hund_ff)
                      * RECIP_TEN_NARROW_W'(RECIP_TEN_NARROW);
      thou          = thou_prod[RECIP_TEN_NARROW_SHIFT +: HUNDREDS_W];
      tens_wide     = hund_ff - thou * HUNDREDS_W'(DIGIT_BASE);
      tens_digit_in = tens_wide[DIGIT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid6_ff <= 1'b0;
         valid7_ff <= 1'b0;
         valid8_ff <= 1'b0;
      end else if (en) begin
         valid6_ff <= in_valid;
         valid7_ff <= valid6_ff;
         valid8_ff <= valid7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         avg6_ff       <= average;
         tens6_ff      <= tens_in;
         avg7_ff       <= avg6_ff;
         tens7_ff      <= tens6_ff;
         hund_ff       <= hund_in;
         tenths7_ff    <= tenths_in;
         avg8_ff       <= avg7_ff;
         tens8_ff      <= tens_digit_in;
         units8_ff     <= units_in;
         tenths8_ff    <= tenths7_ff;
         tens_seg_ff   <= seg_pattern(tens_digit_in);
         units_seg_ff  <= seg_pattern(units_in);
         tenths_seg_ff <= seg_pattern(tenths7_ff);
      end
   end

   assign out_valid       = valid8_ff;
   assign out_average     = avg8_ff;
   assign tens_digit      = tens8_ff;
   assign units_digit     = units8_ff;
   assign tenths_digit    = tenths8_ff;
   assign tens_segments   = tens_seg_ff;
   assign units_segments  = units_seg_ff;
   assign tenths_segments = tenths_seg_ff;

endmodule

@@ hdl/averaged_temperature_seven_segment.sv @@
// Averaged temperature display driver.
// The req channel carries one raw 10-bit converter sample per transaction.
// The rsp channel returns, for every accepted sample, the average of the
// last WINDOW_LEN scaled samples in tenths of a degree, its three decimal
// digits and their active-low seven-segment patterns (segments a..g on
// bits 0..6).
// A transaction completes on a rising edge with valid high and stall low.
// An accepted sample goes through the scale stages, the running total, the
// average estimate and correction and the digit stages before rsp shows it.
// Throughput is one sample per cycle unless rsp stalls; the whole pipeline
// advances together, and the window is a chain of cells that shifts once per
// accepted sample, so one running-total update per cycle sets the rate.
// While rsp_stall holds a waiting result, the pipeline freezes and req_stall
// rises in the same cycle, so nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears the window and its
// total to zero, so the first WINDOW_LEN - 1 averages include zeros.
module averaged_temperature_seven_segment
   import atss_pkg::*;
#(
   parameter int WINDOW_LEN = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_adc_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [AVG_W-1:0]    rsp_average_tenths,
   output logic [DIGIT_W-1:0]  rsp_tens_digit,
   output logic [DIGIT_W-1:0]  rsp_units_digit,
   output logic [DIGIT_W-1:0]  rsp_tenths_digit,
   output logic [SEG_W-1:0]    rsp_tens_segments,
   output logic [SEG_W-1:0]    rsp_units_segments,
   output logic [SEG_W-1:0]    rsp_tenths_segments
);

   localparam int TOTAL_W = $clog2(WINDOW_LEN * SCALED_MAX + 1);
   localparam int AVG_PROD_W = 2 * TOTAL_W;
   localparam int AVG_RECIP = (2 ** TOTAL_W) / WINDOW_LEN;

   logic                  en;
   logic                  accept;
   logic                  scaled_valid;
   logic [SCALED_W-1:0]   scaled_value;
   logic                  shift_en;
   logic [SCALED_W-1:0]   tap [WINDOW_LEN];
   logic [SCALED_W-1:0]   oldest;
   logic [TOTAL_W-1:0]    total_in, total_ff;
   logic                  valid3_ff, valid4_ff, valid5_ff;
   logic [AVG_PROD_W-1:0] avg_prod;
   logic [AVG_W-1:0]      est_in, est_ff;
   logic [TOTAL_W-1:0]    total4_ff;
   logic [TOTAL_W-1:0]    avg_rem;
   logic [AVG_W-1:0]      avg_in, avg_ff;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   atss_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .sample    (req_adc_sample),
      .out_valid (scaled_valid),
      .value     (scaled_value)
   );

   assign shift_en = en && scaled_valid;

   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_window
      if (i == 0) begin : g_head
         atss_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .d_in     (scaled_value),
            .d_out    (tap[i])
         );
      end else begin : g_body
         atss_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .d_in     (tap[i-1]),
            .d_out    (tap[i])
         );
      end
   end

   assign oldest   = tap[WINDOW_LEN-1];
   assign total_in = total_ff + TOTAL_W'(scaled_value) - TOTAL_W'(oldest);

   always_comb begin
      avg_prod = AVG_PROD_W'(total_ff) * AVG_PROD_W'(AVG_RECIP);
      est_in   = avg_prod[TOTAL_W +: AVG_W];
   end

   always_comb begin
      avg_rem = total4_ff - TOTAL_W'(est_ff) * TOTAL_W'(WINDOW_LEN);
      avg_in  = est_ff + AVG_W'(avg_rem >= TOTAL_W'(WINDOW_LEN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= '0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else if (en) begin
         if (scaled_valid) begin
            total_ff <= total_in;
         end
         valid3_ff <= scaled_valid;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         est_ff    <= est_in;
         total4_ff <= total_ff;
         avg_ff    <= avg_in;
      end
   end

   atss_digits u_digits (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (valid5_ff),
      .average         (avg_ff),
      .out_valid       (rsp_valid),
      .out_average     (rsp_average_tenths),
      .tens_digit      (rsp_tens_digit),
      .units_digit     (rsp_units_digit),
      .tenths_digit    (rsp_tenths_digit),
      .tens_segments   (rsp_tens_segments),
      .units_segments  (rsp_units_segments),
      .tenths_segments (rsp_tenths_segments)
   );

endmodule
